// ===== hw/rtl/int8_dot_product_dequantize_core_macros.svh =====
// Assertion helpers, sampled on clk and off during rst.
`ifndef INT8_DOT_PRODUCT_DEQUANTIZE_CORE_MACROS_SVH
`define INT8_DOT_PRODUCT_DEQUANTIZE_CORE_MACROS_SVH

`define IDP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idp assertion failed");

`define IDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idp assertion failed");

`endif

// ===== hw/rtl/idp_pkg.sv =====
package idp_pkg;

  localparam int LANES_MAX = 8;
  localparam int LANE_SUM_W = 19;
  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [7:0] I2F_EXP_TOP = 8'd158;

  typedef enum logic {
    REG_SCALE_A = 1'b0,
    REG_SCALE_B = 1'b1
  } reg_idx_t;

  function automatic logic [3:0] lzc8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/int8_dot_product_dequantize_core.sv =====
// A transaction's result leaves after its last item passes 3 multiply-accumulate
// stages, 4 int-to-float stages and 6 float-multiply stages.
// Throughput: one item per cycle while item_stall is low; a stalled result register lets
// earlier stages keep filling until the pipeline is full.
// Reset: clears the accumulator and all stage valids, sets both scales to 1.0.
module int8_dot_product_dequantize_core #(
  parameter int LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [63:0] act_bytes,
  input  logic [63:0] weight_bytes,
  input  logic        last_item,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [31:0] dot_sum,
  output logic [31:0] scaled_bits,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import idp_pkg::*;

  logic [31:0] scale_a_bits, scale_b_bits;
  logic        mac_ready, mac_valid, i2f_ready, i2f_valid, mul_ready;
  logic [31:0] mac_sum, i2f_bits, i2f_tag, scale_bits, mul_tag;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALE_B) ? scale_b_bits : scale_a_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_a_bits <= SCALE_RESET;
      scale_b_bits <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SCALE_B) scale_b_bits <= pwdata;
      else scale_a_bits <= pwdata;
    end
  end

  idp_fmul u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (1'b1),
    .in_ready (),
    .in_a     (scale_a_bits),
    .in_b     (scale_b_bits),
    .in_tag   (32'd0),
    .out_valid(),
    .out_ready(1'b1),
    .out_bits (scale_bits),
    .out_tag  ()
  );

  idp_mac #(.LANES(LANES)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_ready (mac_ready),
    .act      (act_bytes),
    .wgt      (weight_bytes),
    .last     (last_item),
    .out_valid(mac_valid),
    .out_ready(i2f_ready),
    .out_sum  (mac_sum)
  );

  idp_i2f u_i2f (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mac_valid),
    .in_ready (i2f_ready),
    .in_int   (mac_sum),
    .out_valid(i2f_valid),
    .out_ready(mul_ready),
    .out_bits (i2f_bits),
    .out_tag  (i2f_tag)
  );

  idp_fmul u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (i2f_valid),
    .in_ready (mul_ready),
    .in_a     (i2f_bits),
    .in_b     (scale_bits),
    .in_tag   (i2f_tag),
    .out_valid(result_valid),
    .out_ready(!result_stall),
    .out_bits (scaled_bits),
    .out_tag  (mul_tag)
  );

  assign item_stall = !mac_ready;
  assign dot_sum = $signed(mul_tag);

endmodule

// ===== hw/rtl/idp_mac.sv =====
`include "int8_dot_product_dequantize_core_macros.svh"

module idp_mac #(
  parameter int LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] act,
  input  logic [63:0] wgt,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum
);
  import idp_pkg::*;

  logic        v1, v2, v3;
  logic        move1, move2, move3;
  logic [63:0] act1, wgt1;
  logic        last1, last2;
  logic signed [LANE_SUM_W-1:0] lsum2;
  logic signed [LANE_SUM_W-1:0] lsum_next;
  logic [31:0] acc, acc_next, sum3;

  assign move3 = !v3 || out_ready;
  assign move2 = !v2 || move3;
  assign move1 = !v1 || move2;
  assign in_ready = move1;

  always_comb begin
    lsum_next = '0;
    for (int i = 0; i < LANES && i < LANES_MAX; i++) begin
      lsum_next = lsum_next + LANE_SUM_W'($signed(act1[8*i +: 8]) * $signed(wgt1[8*i +: 8]));
    end
  end

  assign acc_next = acc + 32'(lsum2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      acc <= '0;
    end else begin
      if (move1) v1 <= in_valid;
      if (move2) v2 <= v1;
      if (move3) begin
        v3 <= v2 && last2;
        if (v2) acc <= last2 ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      act1 <= act;
      wgt1 <= wgt;
      last1 <= last;
    end
    if (move2) begin
      lsum2 <= lsum_next;
      last2 <= last1;
    end
    if (move3 && v2) sum3 <= acc_next;
  end

  assign out_valid = v3;
  assign out_sum = sum3;

  `IDP_ASSERT_NEXT(a_nonlast_no_result, move3 && v2 && !last2, !v3)
  `IDP_ASSERT_NEXT(a_last_clears, move3 && v2 && last2, v3 && acc == '0)
  `IDP_ASSERT_NEXT(a_acc_holds, !(move3 && v2), $stable(acc))
  `IDP_ASSERT_SAME(a_acc_reset, $past(rst), acc == '0)

endmodule

// ===== hw/rtl/idp_i2f.sv =====
module idp_i2f (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_int,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bits,
  output logic [31:0] out_tag
);
  import idp_pkg::*;

  logic [3:0] v, move;
  logic [31:0] x1, tag1, tag2, tag3, tag4;
  logic [31:0] mag2, n3, bits4;
  logic        sgn2, sgn3, zero3;
  logic [3:0]  lzb2 [4];
  logic [4:0]  lz3;
  logic [31:0] mag_c, n_c, bits_c;
  logic [3:0]  lzb_c [4];
  logic [4:0]  lz_c;
  logic [7:0]  exp_c;
  logic        inc_c, found;
  logic [30:0] packed_c;

  always_comb begin
    move[3] = !v[3] || out_ready;
    for (int k = 2; k >= 0; k--) move[k] = !v[k] || move[k+1];
  end
  assign in_ready = move[0];

  always_comb begin
    mag_c = x1[31] ? (~x1 + 32'd1) : x1;
    for (int j = 0; j < 4; j++) lzb_c[j] = lzc8(mag_c[31-8*j -: 8]);
  end

  always_comb begin
    found = 1'b0;
    lz_c = '0;
    for (int j = 0; j < 4; j++) begin
      if (!found && lzb2[j] != 4'd8) begin
        lz_c = 5'(8*j + int'(lzb2[j]));
        found = 1'b1;
      end
    end
    n_c = mag2 << lz_c;
  end

  always_comb begin
    exp_c = I2F_EXP_TOP - 8'(lz3);
    inc_c = n3[7] && ((|n3[6:0]) || n3[8]);
    packed_c = {exp_c, n3[30:8]} + 31'(inc_c);
    bits_c = zero3 ? 32'd0 : {sgn3, packed_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (move[0]) v[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (move[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      x1 <= in_int;
      tag1 <= in_int;
    end
    if (move[1]) begin
      mag2 <= mag_c;
      sgn2 <= x1[31];
      lzb2 <= lzb_c;
      tag2 <= tag1;
    end
    if (move[2]) begin
      n3 <= n_c;
      lz3 <= lz_c;
      sgn3 <= sgn2;
      zero3 <= (mag2 == '0);
      tag3 <= tag2;
    end
    if (move[3]) begin
      bits4 <= bits_c;
      tag4 <= tag3;
    end
  end

  assign out_valid = v[3];
  assign out_bits = bits4;
  assign out_tag = tag4;

endmodule

// ===== hw/rtl/idp_fmul.sv =====
module idp_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  input  logic [31:0] in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bits,
  output logic [31:0] out_tag
);
  import idp_pkg::*;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_INF,
    KIND_NAN
  } kind_t;

  logic [5:0] v, move;
  logic [31:0] tag [6];

  // stage 1: operands
  logic [31:0] a1, b1;
  // stage 2: product
  logic [47:0] prod2;
  logic signed [9:0] t2;
  logic sgn2;
  kind_t kind2;
  // stage 3: byte leading zeros
  logic [47:0] prod3;
  logic signed [9:0] t3;
  logic sgn3;
  kind_t kind3;
  logic [3:0] lzb3 [6];
  // stage 4: shift control
  logic [47:0] prod4;
  logic [5:0] left4, right4;
  logic use_right4, sgn4;
  logic signed [9:0] expo4;
  kind_t kind4;
  // stage 5: normalized
  logic [47:0] m5;
  logic stk5, ovf5, sgn5;
  logic [7:0] exp5;
  kind_t kind5;
  // stage 6: result
  logic [31:0] bits6;

  logic [7:0] ea_f, eb_f;
  logic [23:0] ma, mb;
  logic [7:0] ea, eb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  kind_t kind_c;
  logic [47:0] prod_c;
  logic signed [9:0] t_c;
  logic [3:0] lzb_c [6];
  logic [5:0] lz_c, left_c, right_c;
  logic found, use_right_c;
  logic signed [9:0] t_m1, lzs, expo_c, rsh;
  logic [47:0] m_c, mask_c;
  logic stk_c;
  logic inc_c;
  logic [30:0] packed_c;
  logic [31:0] bits_c;

  always_comb begin
    move[5] = !v[5] || out_ready;
    for (int k = 4; k >= 0; k--) move[k] = !v[k] || move[k+1];
  end
  assign in_ready = move[0];

  always_comb begin
    ea_f = a1[30:23];
    eb_f = b1[30:23];
    a_nan = (ea_f == 8'hFF) && (a1[22:0] != '0);
    b_nan = (eb_f == 8'hFF) && (b1[22:0] != '0);
    a_inf = (ea_f == 8'hFF) && (a1[22:0] == '0);
    b_inf = (eb_f == 8'hFF) && (b1[22:0] == '0);
    a_zero = (ea_f == 8'h00) && (a1[22:0] == '0);
    b_zero = (eb_f == 8'h00) && (b1[22:0] == '0);
    ma = {ea_f != 8'h00, a1[22:0]};
    mb = {eb_f != 8'h00, b1[22:0]};
    ea = (ea_f == 8'h00) ? 8'd1 : ea_f;
    eb = (eb_f == 8'h00) ? 8'd1 : eb_f;
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) kind_c = KIND_NAN;
    else if (a_inf || b_inf) kind_c = KIND_INF;
    else if (a_zero || b_zero) kind_c = KIND_ZERO;
    else kind_c = KIND_NUM;
    prod_c = ma * mb;
    t_c = $signed(10'(ea) + 10'(eb) - 10'd126);
  end

  always_comb begin
    for (int j = 0; j < 6; j++) lzb_c[j] = lzc8(prod2[47-8*j -: 8]);
  end

  always_comb begin
    found = 1'b0;
    lz_c = '0;
    for (int j = 0; j < 6; j++) begin
      if (!found && lzb3[j] != 4'd8) begin
        lz_c = 6'(8*j + int'(lzb3[j]));
        found = 1'b1;
      end
    end
    t_m1 = t3 - 10'sd1;
    lzs = $signed({4'b0, lz_c});
    rsh = 10'sd1 - t3;
    left_c = '0;
    right_c = '0;
    use_right_c = 1'b0;
    expo_c = '0;
    if (t_m1 >= lzs) begin
      left_c = lz_c;
      expo_c = t3 - lzs;
    end else if (t_m1 >= 10'sd0) begin
      left_c = t_m1[5:0];
    end else begin
      use_right_c = 1'b1;
      right_c = (rsh > 10'sd48) ? 6'd48 : rsh[5:0];
    end
  end

  always_comb begin
    mask_c = (48'd1 << right4) - 48'd1;
    if (use_right4) begin
      m_c = prod4 >> right4;
      stk_c = |(prod4 & mask_c);
    end else begin
      m_c = prod4 << left4;
      stk_c = 1'b0;
    end
  end

  always_comb begin
    inc_c = m5[23] && ((|m5[22:0]) || stk5 || m5[24]);
    packed_c = {exp5, m5[46:24]} + 31'(inc_c);
    case (kind5)
      KIND_NAN:  bits_c = QNAN;
      KIND_INF:  bits_c = {sgn5, 8'hFF, 23'd0};
      KIND_ZERO: bits_c = {sgn5, 31'd0};
      default:   bits_c = ovf5 ? {sgn5, 8'hFF, 23'd0} : {sgn5, packed_c};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (move[0]) v[0] <= in_valid;
      for (int k = 1; k < 6; k++) begin
        if (move[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      a1 <= in_a;
      b1 <= in_b;
      tag[0] <= in_tag;
    end
    for (int k = 1; k < 6; k++) begin
      if (move[k]) tag[k] <= tag[k-1];
    end
    if (move[1]) begin
      prod2 <= prod_c;
      t2 <= t_c;
      sgn2 <= a1[31] ^ b1[31];
      kind2 <= kind_c;
    end
    if (move[2]) begin
      prod3 <= prod2;
      t3 <= t2;
      sgn3 <= sgn2;
      kind3 <= kind2;
      lzb3 <= lzb_c;
    end
    if (move[3]) begin
      prod4 <= prod3;
      left4 <= left_c;
      right4 <= right_c;
      use_right4 <= use_right_c;
      expo4 <= expo_c;
      sgn4 <= sgn3;
      kind4 <= kind3;
    end
    if (move[4]) begin
      m5 <= m_c;
      stk5 <= stk_c;
      ovf5 <= (expo4 >= 10'sd255);
      exp5 <= expo4[7:0];
      sgn5 <= sgn4;
      kind5 <= kind4;
    end
    if (move[5]) bits6 <= bits_c;
  end

  assign out_valid = v[5];
  assign out_bits = bits6;
  assign out_tag = tag[5];

endmodule
